FILE: rtl/sensorless_bldc_commutator_macros.svh
// Assertion macros for the sensorless BLDC commutator.
// Used by the top level; needs clk and arst_n in scope.
`ifndef SENSORLESS_BLDC_COMMUTATOR_MACROS_SVH
`define SENSORLESS_BLDC_COMMUTATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define BLDC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("commutator assertion failed");
// Check a property on every clock edge, reset included.
`define BLDC_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("commutator assertion failed");
`else
`define BLDC_ASSERT(lbl, prop)
`define BLDC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: rtl/bldc_pkg.sv
// Shared types, codes and the commutation table of the BLDC commutator.
// No dependencies.
package bldc_pkg;
	localparam logic [2:0] CMD_START   = 3'd0;
	localparam logic [2:0] CMD_STOP    = 3'd1;
	localparam logic [2:0] CMD_COMP    = 3'd2;
	localparam logic [2:0] CMD_COMPARE = 3'd3;
	localparam logic [2:0] CMD_OVF     = 3'd4;

	localparam logic [2:0] STG_OFF    = 3'd0;
	localparam logic [2:0] STG_LOCK   = 3'd1;
	localparam logic [2:0] STG_RAMP   = 3'd2;
	localparam logic [2:0] STG_STAB   = 3'd3;
	localparam logic [2:0] STG_CLOSED = 3'd4;

	localparam logic [2:0] REG_RAMP_START = 3'd0;
	localparam logic [2:0] REG_RAMP_END   = 3'd1;
	localparam logic [2:0] REG_RAMP_DUR   = 3'd2;
	localparam logic [2:0] REG_LOCK_OVF   = 3'd3;
	localparam logic [2:0] REG_LOCK_STEPS = 3'd4;
	localparam logic [2:0] REG_STAB_STEPS = 3'd5;
	localparam logic [2:0] REG_MARGIN     = 3'd6;

	// Number of quotient bits produced by the fraction divider.
	localparam int FRAC_BITS = 16;

	typedef struct packed {
		logic exec;
		logic div_step;
		logic mul1;
		logic mul2;
		logic mul3;
		logic fin;
		logic load_out;
	} ctl_t;

	typedef struct packed {
		logic ramp_req;
	} sts_t;

	typedef struct packed {
		logic [1:0] sense;
		logic [1:0] drive;
		logic       hi_side;
		logic       tgt;
		logic [2:0] next_step;
	} comm_t;

	// Six-step table: which phase floats, which switch changes, next step.
	function automatic comm_t comm_fn(input logic [2:0] step);
		comm_t c;
		c.tgt = step[0];
		c.next_step = (step >= 3'd6) ? 3'd1 : step + 3'd1;
		unique case (step)
			3'd1: begin c.sense = 2'd2; c.drive = 2'd2; c.hi_side = 1'b1; end
			3'd2: begin c.sense = 2'd0; c.drive = 2'd3; c.hi_side = 1'b0; end
			3'd3: begin c.sense = 2'd1; c.drive = 2'd1; c.hi_side = 1'b1; end
			3'd4: begin c.sense = 2'd2; c.drive = 2'd2; c.hi_side = 1'b0; end
			3'd5: begin c.sense = 2'd0; c.drive = 2'd3; c.hi_side = 1'b1; end
			default: begin c.sense = 2'd1; c.drive = 2'd1; c.hi_side = 1'b0; end
		endcase
		return c;
	endfunction
endpackage

FILE: rtl/bldc_ctrl.sv
// Controller state machine of the BLDC commutator.
// Depends on bldc_pkg.
module bldc_ctrl import bldc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output ctl_t ctl
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_MUL1 = 3'd3;
	localparam logic [2:0] S_MUL2 = 3'd4;
	localparam logic [2:0] S_MUL3 = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0] state_q;
	logic [3:0] cnt_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Commands decoded from the state.
	always_comb begin
		ctl          = '0;
		ctl.exec     = (state_q == S_EXEC);
		ctl.div_step = (state_q == S_DIV);
		ctl.mul1     = (state_q == S_MUL1);
		ctl.mul2     = (state_q == S_MUL2);
		ctl.mul3     = (state_q == S_MUL3);
		ctl.fin      = (state_q == S_FIN);
		ctl.load_out = (state_q == S_DONE) && out_free;
	end

	// Sequencer and output word valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_EXEC;
				S_EXEC: begin
					cnt_q   <= '0;
					state_q <= sts.ramp_req ? S_DIV : S_DONE;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(FRAC_BITS - 1)) state_q <= S_MUL1;
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_MUL3;
				S_MUL3: state_q <= S_FIN;
				S_FIN:  state_q <= S_DONE;
				default: begin
					if (out_free)
						state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

FILE: rtl/bldc_dp.sv
// Datapath of the BLDC commutator: configuration, motor state, ramp arithmetic.
// Depends on bldc_pkg; driven by bldc_ctrl commands.
module bldc_dp import bldc_pkg::*; #(
	parameter int TIMER_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_take,
	input  logic [2:0]  command,
	input  logic [15:0] timer_count,
	input  logic        comparator_level,
	input  ctl_t        ctl,
	output sts_t        sts,
	output logic [1:0]  high_side_phase,
	output logic [1:0]  low_side_phase,
	output logic [1:0]  sense_phase,
	output logic [15:0] period_out,
	output logic [15:0] crossing_time,
	output logic        motor_running,
	output logic [2:0]  stage,
	output logic        stall_stop,
	output logic        commutated
);
	localparam int TW = TIMER_BITS;
	localparam int WW = TW + 12;
	localparam logic [WW-1:0] TMAXW = {{12{1'b0}}, {TW{1'b1}}};

	// Configuration registers.
	logic [15:0] rsp_q, rep_q, rdur_q, lovf_q, ssteps_q;
	logic [7:0]  lsteps_q;
	logic [9:0]  margin_q;

	// Captured input word.
	logic [2:0]    cmd_q;
	logic [TW-1:0] tc_q;
	logic          lvl_q;

	// Motor state.
	logic [2:0]    step_q, stage_q;
	logic [1:0]    hi_q, lo_q, sense_q;
	logic          tgt_q, seen_q, stall_q, comm_q;
	logic [TW-1:0] accum_q, lst_q, phalf_q, per_q, latch_q;
	logic [15:0]   elapsed_q, stabc_q, ovf_q;
	logic [7:0]    lockc_q;

	// Ramp arithmetic.
	logic [16:0] rem_q;
	logic [15:0] quo_q;
	logic        big_q;
	logic [16:0] f2_q;
	logic [17:0] s_q;
	logic [15:0] r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_q    <= 16'd40000;
			rep_q    <= 16'd4000;
			rdur_q   <= 16'd2000;
			lovf_q   <= 16'd10;
			lsteps_q <= 8'd6;
			ssteps_q <= 16'd500;
			margin_q <= 10'd10;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RAMP_START: rsp_q    <= cfg_data;
				REG_RAMP_END:   rep_q    <= cfg_data;
				REG_RAMP_DUR:   rdur_q   <= cfg_data;
				REG_LOCK_OVF:   lovf_q   <= cfg_data;
				REG_LOCK_STEPS: lsteps_q <= cfg_data[7:0];
				REG_STAB_STEPS: ssteps_q <= cfg_data;
				REG_MARGIN:     margin_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_q <= command;
			tc_q  <= TW'(timer_count);
			lvl_q <= comparator_level;
		end
	end

	assign sts.ramp_req = (cmd_q == CMD_COMPARE) && (stage_q == STG_RAMP);

	// Crossing time accumulation, saturated to the timer range.
	logic [TW:0]   acc_sum;
	logic [TW-1:0] acc_add, acc_eff;
	assign acc_sum = {1'b0, accum_q} + {1'b0, TW'(tc_q - lst_q)};
	assign acc_add = acc_sum[TW] ? {TW{1'b1}} : acc_sum[TW-1:0];
	assign acc_eff = seen_q ? accum_q : acc_add;

	// Closed loop period: half period plus crossing time, clamped.
	logic [WW-1:0] s1, s1s, twice, mg, lo_b, hi_b, hi_raw, cl;
	always_comb begin
		s1     = WW'(phalf_q) + WW'(acc_eff);
		s1s    = (s1 > TMAXW) ? TMAXW : s1;
		twice  = WW'(phalf_q) << 1;
		mg     = WW'(margin_q);
		lo_b   = (twice > mg) ? twice - mg : '0;
		lo_b   = (lo_b > TMAXW) ? TMAXW : lo_b;
		hi_raw = twice + mg;
		hi_b   = (hi_raw > TMAXW) ? TMAXW : hi_raw;
		cl     = s1s;
		if (cl < lo_b) cl = lo_b;
		if (cl > hi_b) cl = hi_b;
	end

	// Counters and ramp entry decisions.
	logic [16:0]   esum, stsum, ovsum;
	logic [15:0]   el_new, stabc_new, ovf_new, need;
	logic [TW-1:0] per_start;
	logic [2:0]    ramp_entry_stage, stab_entry_stage;
	always_comb begin
		esum      = 17'(elapsed_q) + 17'(16'(per_q >> 8));
		el_new    = esum[16] ? 16'hFFFF : esum[15:0];
		stsum     = 17'(stabc_q) + 17'd1;
		stabc_new = stsum[16] ? 16'hFFFF : stsum[15:0];
		ovsum     = 17'(ovf_q) + 17'd1;
		ovf_new   = ovsum[16] ? 16'hFFFF : ovsum[15:0];
		need      = (lovf_q == 16'd0) ? 16'd1 : lovf_q;
		per_start = TW'(rsp_q);
		stab_entry_stage = (ssteps_q == 16'd0) ? STG_CLOSED : STG_STAB;
		ramp_entry_stage = (32'(per_start) <= 32'(rep_q)) ? stab_entry_stage : STG_RAMP;
	end

	// Whether this event commutates, and from which step.
	logic  do_com;
	comm_t cm;
	always_comb begin
		do_com = 1'b0;
		if (cmd_q == CMD_START)
			do_com = (lsteps_q != 8'd0);
		else if (cmd_q == CMD_COMPARE)
			do_com = (stage_q >= STG_RAMP);
		else if (cmd_q == CMD_OVF)
			do_com = (stage_q == STG_LOCK) && (ovf_new >= need) && (lockc_q < lsteps_q);
		cm = comm_fn((cmd_q == CMD_START) ? 3'd1 : step_q);
	end

	// Shared multiplier for the three ramp products.
	logic [17:0] mul_a, mul_b;
	logic [35:0] prod;
	logic [16:0] frac;
	logic [15:0] dspan;
	always_comb begin
		frac  = big_q ? 17'h10000 : {1'b0, quo_q};
		dspan = (rsp_q >= rep_q) ? rsp_q - rep_q : rep_q - rsp_q;
		mul_a = 18'(frac);
		mul_b = 18'(frac);
		if (ctl.mul2) begin
			mul_a = 18'(f2_q);
			mul_b = 18'd196608 - (18'(frac) << 1);
		end else if (ctl.mul3) begin
			mul_a = 18'(dspan);
			mul_b = s_q;
		end
		prod = 36'(mul_a) * 36'(mul_b);
	end

	logic [16:0] rem2;
	logic [15:0] ramp_res;
	assign rem2     = {rem_q[15:0], 1'b0};
	assign ramp_res = (rsp_q >= rep_q) ? rsp_q - r_q : rsp_q + r_q;

	// Ramp arithmetic registers.
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			rem_q <= 17'(el_new);
			quo_q <= '0;
			big_q <= (rdur_q == 16'd0) || (el_new >= rdur_q);
		end else if (ctl.div_step) begin
			if (rem2 >= 17'(rdur_q)) begin
				rem_q <= rem2 - 17'(rdur_q);
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= rem2;
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
		if (ctl.mul1) f2_q <= prod[32:16];
		if (ctl.mul2) s_q  <= prod[33:16];
		if (ctl.mul3) r_q  <= prod[31:16];
	end

	// Motor state update: one event per exec command, and the end of a ramp step on fin.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= 3'd1;
			stage_q   <= STG_OFF;
			hi_q      <= '0;
			lo_q      <= '0;
			sense_q   <= '0;
			tgt_q     <= 1'b0;
			seen_q    <= 1'b0;
			stall_q   <= 1'b0;
			comm_q    <= 1'b0;
			accum_q   <= '0;
			lst_q     <= '0;
			phalf_q   <= '0;
			per_q     <= '0;
			latch_q   <= '0;
			elapsed_q <= '0;
			stabc_q   <= '0;
			ovf_q     <= '0;
			lockc_q   <= '0;
		end else if (ctl.exec) begin
			stall_q <= (cmd_q == CMD_OVF) && (stage_q == STG_CLOSED);
			comm_q  <= do_com;
			unique case (cmd_q)
				CMD_START: begin
					// The first lock step commutates straight from step one.
					step_q    <= do_com ? cm.next_step : 3'd1;
					lo_q      <= (do_com && !cm.hi_side) ? cm.drive : 2'd1;
					hi_q      <= (do_com && cm.hi_side) ? cm.drive : 2'd0;
					stage_q   <= (lsteps_q == 8'd0) ? ramp_entry_stage : STG_LOCK;
					elapsed_q <= '0;
					phalf_q   <= TW'(rep_q >> 1);
					lockc_q   <= (lsteps_q != 8'd0) ? 8'd1 : 8'd0;
					ovf_q     <= '0;
					if (lsteps_q == 8'd0) begin
						per_q   <= per_start;
						latch_q <= per_start;
						stabc_q <= '0;
					end
				end
				CMD_STOP: begin
					stage_q <= STG_OFF;
					hi_q    <= '0;
					lo_q    <= '0;
				end
				CMD_COMP: begin
					if (stage_q != STG_OFF) begin
						if (lvl_q != tgt_q) begin
							accum_q <= acc_add;
							seen_q  <= 1'b1;
						end else begin
							lst_q  <= tc_q;
							seen_q <= 1'b0;
						end
					end
				end
				CMD_COMPARE: begin
					if (stage_q >= STG_RAMP) begin
						latch_q <= acc_eff;
						if (stage_q == STG_CLOSED) begin
							phalf_q <= TW'(cl >> 1);
							per_q   <= TW'(cl);
						end else if (stage_q == STG_RAMP) begin
							elapsed_q <= el_new;
						end else begin
							stabc_q <= stabc_new;
							if (stabc_new >= ssteps_q) stage_q <= STG_CLOSED;
						end
					end
				end
				CMD_OVF: begin
					if (stage_q != STG_OFF) begin
						// A lock step restarts the overflow count.
						ovf_q <= do_com ? '0 : ovf_new;
						if (stage_q == STG_CLOSED) begin
							stage_q <= STG_OFF;
							hi_q    <= '0;
							lo_q    <= '0;
						end else if (stage_q == STG_LOCK && ovf_new >= need) begin
							if (lockc_q < lsteps_q) begin
								lockc_q <= lockc_q + 8'd1;
							end else begin
								stage_q <= ramp_entry_stage;
								per_q   <= per_start;
								latch_q <= per_start;
								stabc_q <= '0;
							end
						end
					end
				end
				default: ;
			endcase
			// Commutation sets the drive and clears the crossing state.
			if (do_com) begin
				accum_q <= '0;
				lst_q   <= '0;
				seen_q  <= 1'b0;
				tgt_q   <= cm.tgt;
				sense_q <= cm.sense;
				if (cmd_q != CMD_START) begin
					step_q <= cm.next_step;
					if (cm.hi_side) hi_q <= cm.drive;
					else            lo_q <= cm.drive;
				end
			end
		end else if (ctl.fin) begin
			// End of a ramp step: new period, maybe leave the ramp.
			per_q <= TW'(ramp_res);
			if (32'(TW'(ramp_res)) <= 32'(rep_q)) begin
				stage_q <= stab_entry_stage;
				stabc_q <= '0;
			end
		end
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			high_side_phase <= hi_q;
			low_side_phase  <= lo_q;
			sense_phase     <= sense_q;
			period_out      <= 16'(per_q);
			crossing_time   <= 16'(latch_q);
			motor_running   <= (stage_q != STG_OFF);
			stage           <= stage_q;
			stall_stop      <= stall_q;
			commutated      <= comm_q;
		end
	end
endmodule

FILE: rtl/sensorless_bldc_commutator.sv
// An accepted word passes through EXEC and then DONE, where the result is loaded
// into the output register; a period compare during the ramp also runs the 16-bit
// fraction divider and three shared multiplies in between. One word is handled at
// a time; the next is accepted once the result is written to the output register.
// Reset: arst_n asynchronous, active low; registers take their defaults.
module sensorless_bldc_commutator import bldc_pkg::*; #(
	parameter int TIMER_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [15:0] timer_count,
	input  logic        comparator_level,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  high_side_phase,
	output logic [1:0]  low_side_phase,
	output logic [1:0]  sense_phase,
	output logic [15:0] period_out,
	output logic [15:0] crossing_time,
	output logic        motor_running,
	output logic [2:0]  stage,
	output logic        stall_stop,
	output logic        commutated
);
`include "sensorless_bldc_commutator_macros.svh"

	ctl_t ctl;
	sts_t sts;

	bldc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.sts(sts), .ctl(ctl)
	);

	bldc_dp #(.TIMER_BITS(TIMER_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_take(in_valid && in_ready),
		.command(command), .timer_count(timer_count),
		.comparator_level(comparator_level),
		.ctl(ctl), .sts(sts),
		.high_side_phase(high_side_phase), .low_side_phase(low_side_phase),
		.sense_phase(sense_phase), .period_out(period_out),
		.crossing_time(crossing_time), .motor_running(motor_running),
		.stage(stage), .stall_stop(stall_stop), .commutated(commutated)
	);

	// A word in progress blocks the next one.
	`BLDC_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready)
	// A stall stop always leaves the motor off.
	`BLDC_ASSERT(a_stall_off, (out_valid && stall_stop) |-> (stage == STG_OFF))
	// A commutation only happens with the motor driven.
	`BLDC_ASSERT(a_comm_running, (out_valid && commutated) |-> motor_running)
	// The running flag follows the stage.
	`BLDC_ASSERT(a_run_stage, out_valid |-> (motor_running == (stage != STG_OFF)))
endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the sensorless BLDC six-step commutator.
// Depends on rtl/bldc_pkg.sv and rtl/sensorless_bldc_commutator.sv.
// A scoreboard class predicts each result word from the accepted event words.
module testbench;
	import bldc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] CMD_LAST_KNOWN = CMD_OVF;
	localparam int SETTLE_CYCLES = 30;

	typedef struct packed {
		logic [1:0]  high_side;
		logic [1:0]  low_side;
		logic [1:0]  sense;
		logic [15:0] period;
		logic [15:0] crossing;
		logic        running;
		logic [2:0]  stage;
		logic        stall;
		logic        commutated;
	} status_t;

	// Predicts the commutator and holds the status words still to come.
	class commutation_board;
		logic [15:0] start_period, end_period, duration, lock_ovf, stab_steps;
		logic [7:0]  lock_steps;
		logic [9:0]  margin;
		logic [2:0]  step, run_stage;
		logic [1:0]  hi_drv, lo_drv, sense_sel;
		logic        target, seen;
		logic [15:0] accum, low_start, half_period, period, elapsed;
		logic [15:0] stab_count, ovf_count, latched_crossing;
		logic [7:0]  lock_count;
		status_t     pending_status[$];
		int          errors;

		function new();
			start_period = 16'd40000; end_period = 16'd4000; duration = 16'd2000;
			lock_ovf = 16'd10; lock_steps = 8'd6; stab_steps = 16'd500; margin = 10'd10;
			step = 3'd1; run_stage = STG_OFF; hi_drv = '0; lo_drv = '0; sense_sel = '0;
			target = 0; seen = 0; accum = '0; low_start = '0; half_period = '0;
			period = '0; elapsed = '0; stab_count = '0; ovf_count = '0;
			latched_crossing = '0; lock_count = '0; errors = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [15:0] val);
			case (idx)
				REG_RAMP_START: start_period = val;
				REG_RAMP_END:   end_period = val;
				REG_RAMP_DUR:   duration = val;
				REG_LOCK_OVF:   lock_ovf = val;
				REG_LOCK_STEPS: lock_steps = val[7:0];
				REG_STAB_STEPS: stab_steps = val;
				REG_MARGIN:     margin = val[9:0];
				default: ;
			endcase
		endfunction

		// Advance one step of the six-step table.
		function void advance();
			accum = '0; low_start = '0; seen = 0;
			target = step[0];
			case (step)
				3'd1: begin sense_sel = 2'd2; hi_drv = 2'd2; end
				3'd2: begin sense_sel = 2'd0; lo_drv = 2'd3; end
				3'd3: begin sense_sel = 2'd1; hi_drv = 2'd1; end
				3'd4: begin sense_sel = 2'd2; lo_drv = 2'd2; end
				3'd5: begin sense_sel = 2'd0; hi_drv = 2'd3; end
				default: begin sense_sel = 2'd1; lo_drv = 2'd1; end
			endcase
			step = (step >= 3'd6) ? 3'd1 : step + 3'd1;
		endfunction

		function void begin_stabilise();
			run_stage = STG_STAB;
			stab_count = '0;
			if (stab_steps == 0)
				run_stage = STG_CLOSED;
		endfunction

		function void begin_ramp();
			run_stage = STG_RAMP;
			period = start_period;
			latched_crossing = period;
			if (period <= end_period)
				begin_stabilise();
		endfunction

		// S-curve period for the elapsed ramp fraction.
		function logic [15:0] s_curve_period();
			logic [63:0] f, f2, s, d;
			if (duration == 0) begin
				f = 64'd65536;
			end else begin
				f = {32'd0, elapsed, 16'd0} / duration;
				if (f > 64'd65536)
					f = 64'd65536;
			end
			f2 = (f * f) >> 16;
			s = (f2 * (64'd196608 - 2 * f)) >> 16;
			if (start_period >= end_period) begin
				d = start_period - end_period;
				return start_period - 16'((d * s) >> 16);
			end
			d = end_period - start_period;
			return start_period + 16'((d * s) >> 16);
		endfunction

		function logic [15:0] sat16(logic [63:0] v);
			return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
		endfunction

		// Apply one accepted event word and queue the status word it causes.
		function void note_event(logic [2:0] cmd, logic [15:0] tc, logic lvl);
			logic stall, comm;
			logic [63:0] sum, twice, lo, hi;
			logic [15:0] need, since;
			stall = 0; comm = 0;
			since = tc - low_start;
			if (cmd == CMD_START) begin
				step = 3'd1; lo_drv = 2'd1; hi_drv = 2'd0;
				run_stage = STG_LOCK; elapsed = '0;
				half_period = end_period >> 1;
				lock_count = '0; ovf_count = '0;
				if (lock_steps > 0) begin
					advance(); lock_count = 8'd1; comm = 1;
				end else begin
					begin_ramp();
				end
			end else if (cmd == CMD_STOP) begin
				run_stage = STG_OFF; hi_drv = '0; lo_drv = '0;
			end else if (run_stage != STG_OFF && cmd == CMD_COMP) begin
				if (lvl != target) begin
					accum = sat16(64'(accum) + since);
					seen = 1;
				end else begin
					low_start = tc;
					seen = 0;
				end
			end else if (run_stage >= STG_RAMP && cmd == CMD_COMPARE) begin
				if (!seen)
					accum = sat16(64'(accum) + since);
				sum = 64'(sat16(64'(half_period) + accum));
				twice = 2 * 64'(half_period);
				lo = 64'(sat16(twice > margin ? twice - margin : 64'd0));
				hi = 64'(sat16(twice + margin));
				if (sum < lo) sum = lo;
				if (sum > hi) sum = hi;
				latched_crossing = accum;
				if (run_stage == STG_CLOSED)
					half_period = sum[16:1];
				if (run_stage == STG_RAMP) begin
					elapsed = sat16(64'(elapsed) + (period >> 8));
					period = s_curve_period();
				end else if (run_stage == STG_STAB) begin
					stab_count = sat16(64'(stab_count) + 1);
				end
				advance();
				comm = 1;
				if (run_stage == STG_CLOSED) begin
					period = sum[15:0];
				end else if (run_stage == STG_RAMP) begin
					if (period <= end_period)
						begin_stabilise();
				end else if (stab_count >= stab_steps) begin
					run_stage = STG_CLOSED;
				end
			end else if (run_stage != STG_OFF && cmd == CMD_OVF) begin
				ovf_count = sat16(64'(ovf_count) + 1);
				if (run_stage == STG_CLOSED) begin
					run_stage = STG_OFF; hi_drv = '0; lo_drv = '0; stall = 1;
				end else if (run_stage == STG_LOCK) begin
					need = (lock_ovf != 0) ? lock_ovf : 16'd1;
					if (ovf_count >= need) begin
						if (lock_count < lock_steps) begin
							ovf_count = '0;
							advance();
							lock_count = lock_count + 8'd1;
							comm = 1;
						end else begin
							begin_ramp();
						end
					end
				end
			end
			pending_status.push_back('{hi_drv, lo_drv, sense_sel, period, latched_crossing,
				run_stage != STG_OFF, run_stage, stall, comm});
		endfunction

		task report(string what, logic [15:0] got, logic [15:0] want);
			$display("mismatch in %s: got %0d, expected %0d", what, got, want);
			errors++;
		endtask

		// Compare one status word from the block with the oldest prediction.
		task check_status(status_t got);
			status_t want;
			if (pending_status.size() == 0) begin
				$display("status word with no event waiting");
				errors++;
				return;
			end
			want = pending_status.pop_front();
			if (got.high_side !== want.high_side) report("high_side_phase", got.high_side, want.high_side);
			if (got.low_side !== want.low_side) report("low_side_phase", got.low_side, want.low_side);
			if (got.sense !== want.sense) report("sense_phase", got.sense, want.sense);
			if (got.period !== want.period) report("period_out", got.period, want.period);
			if (got.crossing !== want.crossing) report("crossing_time", got.crossing, want.crossing);
			if (got.running !== want.running) report("motor_running", got.running, want.running);
			if (got.stage !== want.stage) report("stage", got.stage, want.stage);
			if (got.stall !== want.stall) report("stall_stop", got.stall, want.stall);
			if (got.commutated !== want.commutated) report("commutated", got.commutated, want.commutated);
		endtask
	endclass

	logic        clk, arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid, in_ready, out_valid, out_ready;
	logic [2:0]  command;
	logic [15:0] timer_count;
	logic        comparator_level;
	logic [1:0]  high_side_phase, low_side_phase, sense_phase;
	logic [15:0] period_out, crossing_time;
	logic        motor_running, stall_stop, commutated;
	logic [2:0]  stage;

	commutation_board board = new();
	bit steady;
	int stall_left;

	sensorless_bldc_commutator u_dut (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("testbench: errors");
		$finish;
	end

	// Gap length: mostly none or short, now and then long.
	function int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Receiver readiness with random stalls.
	initial begin
		out_ready = 0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready <= 0;
				stall_left--;
			end else begin
				out_ready <= 1;
				if ($urandom_range(0, 7) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// Check every status word taken from the block.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				board.check_status('{high_side_phase, low_side_phase, sense_phase, period_out,
					crossing_time, motor_running, stage, stall_stop, commutated});
		end
	end

	task write_reg(logic [2:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		board.set_reg(idx, val);
	endtask

	// Send one event word; returns at the falling edge after acceptance.
	task send_event(logic [2:0] cmd, logic [15:0] tc, logic lvl);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1; command <= cmd; timer_count <= tc; comparator_level <= lvl;
		do @(posedge clk); while (!in_ready);
		board.note_event(cmd, tc, lvl);
		@(negedge clk);
	endtask

	task drain();
		@(negedge clk);
		in_valid <= 0;
		while (board.pending_status.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task configure(logic [15:0] rs, logic [15:0] re, logic [15:0] rd, logic [15:0] lo,
			logic [15:0] ls, logic [15:0] ss, logic [15:0] cm);
		write_reg(REG_RAMP_START, rs);
		write_reg(REG_RAMP_END, re);
		write_reg(REG_RAMP_DUR, rd);
		write_reg(REG_LOCK_OVF, lo);
		write_reg(REG_LOCK_STEPS, ls);
		write_reg(REG_STAB_STEPS, ss);
		write_reg(REG_MARGIN, cm);
	endtask

	// Random events shaped by the predicted stage so startup runs through.
	task random_events(int count);
		int r;
		logic [2:0] cmd;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			steady = (n % 60) < 10;
			if (board.run_stage == STG_OFF)
				cmd = (r < 70) ? CMD_START : 3'($urandom_range(0, 7));
			else if (board.run_stage == STG_LOCK)
				cmd = (r < 80) ? CMD_OVF : 3'($urandom_range(0, 7));
			else if (r < 45) cmd = CMD_COMP;
			else if (r < 86) cmd = CMD_COMPARE;
			else if (r < 90) cmd = CMD_OVF;
			else if (r < 92) cmd = CMD_STOP;
			else if (r < 95) cmd = CMD_START;
			else cmd = 3'($urandom_range(CMD_LAST_KNOWN + 1, 7));
			send_event(cmd, 16'($urandom_range(0, 65535)),
				(r % 3 == 0) ? board.target : ~board.target);
		end
		steady = 0;
	endtask

	initial begin
		arst_n = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
		in_valid = 0; command = CMD_STOP; timer_count = '0; comparator_level = 0;
		steady = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Defaults from reset.
		random_events(50);
		drain();

		// Directed: short startup, every command, field extremes.
		configure(16'd300, 16'd200, 16'd1, 16'd1, 16'd1, 16'd1, 16'd5);
		send_event(CMD_COMP, 16'hFFFF, 1);          // ignored while off
		send_event(CMD_COMPARE, 16'h0000, 0);
		send_event(CMD_OVF, 16'hFFFF, 0);
		send_event(CMD_START, 16'h0000, 0);
		send_event(CMD_COMPARE, 16'h1234, 0);       // ignored during lock
		send_event(CMD_OVF, 16'h0000, 0);
		send_event(CMD_OVF, 16'hFFFF, 1);           // ramp already running, overflow only counts
		send_event(CMD_COMP, 16'h0010, 1);
		send_event(CMD_COMP, 16'hFFFF, 0);
		send_event(CMD_OVF, 16'h0100, 0);           // overflow in ramp only counts
		send_event(CMD_COMPARE, 16'h0200, 0);
		send_event(CMD_COMPARE, 16'hFFFF, 1);
		send_event(CMD_COMP, 16'h0000, 0);
		send_event(CMD_COMP, 16'hFFFF, 1);
		send_event(CMD_COMPARE, 16'h8000, 1);
		send_event(3'd5, 16'h5555, 1);
		send_event(3'd7, 16'hAAAA, 0);
		send_event(CMD_START, 16'h0000, 1);         // restart while running
		send_event(CMD_OVF, 16'h0001, 0);
		send_event(CMD_OVF, 16'h0002, 0);
		for (int k = 0; k < 4; k++) send_event(CMD_COMPARE, 16'(k * 16'h3000), k[0]);
		send_event(CMD_OVF, 16'h0000, 0);           // stall stop in closed loop
		send_event(CMD_STOP, 16'h0000, 0);
		drain();

		configure(16'd2000, 16'd500, 16'd40, 16'd2, 16'd3, 16'd4, 16'd10);
		random_events(150);
		drain();

		configure(16'hFFFF, 16'd0, 16'hFFFF, 16'd1, 16'd255, 16'hFFFF, 16'd1023);
		random_events(100);
		drain();

		// Zero lock steps, ramp already at its end, zero stabilise, zero divisors.
		configure(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		random_events(150);
		drain();

		configure(16'd1000, 16'd3000, 16'd5, 16'd1, 16'd2, 16'd3, 16'd0);
		random_events(150);
		drain();

		if (board.errors == 0 && board.pending_status.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end
endmodule
